FILE: design/irn_pkg.sv
package irn_pkg;

	// Source store geometry and fixed-point format.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 14;

	// Field widths.
	localparam int PIX_W     = 32;
	localparam int POS_W     = 9;
	localparam int SIZE_W    = 9;
	localparam int TRIG_W    = 16;
	localparam int COORD_W   = 8;
	localparam int OUTSZ_W   = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Unsaturated rotated size: up to 2 * 256 * 32768 >> 14, which needs 11 bits.
	localparam int DIM_W = 11;

	// Shared multiplier: 27-bit signed offsets times 17-bit signed trig values.
	localparam int OPA_W  = 27;
	localparam int OPB_W  = TRIG_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = PROD_W + 1;

	// Pixel store.
	localparam int RAM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	// Configuration as seen by the datapath, with sizes already limited.
	typedef struct packed {
		logic [TRIG_W-1:0]  cos_v;
		logic [TRIG_W-1:0]  sin_v;
		logic [TRIG_W:0]    abs_c;
		logic [TRIG_W:0]    abs_s;
		logic [1:0]         quad;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} cfg_t;

endpackage

FILE: design/irn_ram.sv
module irn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port: read each cycle and write when we is high, read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/irn_cfg.sv
module irn_cfg import irn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	logic [TRIG_W-1:0] cos_q;
	logic [TRIG_W-1:0] sin_q;
	logic [1:0]        quad_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [TRIG_W:0]   cos_ext;
	logic [TRIG_W:0]   sin_ext;

	// A size of zero acts as one; a size above the store acts as its maximum.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input int max_v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_W'(max_v)) begin
			r = SIZE_W'(max_v);
		end
		return r;
	endfunction

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= TRIG_W'(1 << FRAC_BITS);
			sin_q    <= '0;
			quad_q   <= '0;
			width_q  <= SIZE_W'(MAX_WIDTH);
			height_q <= SIZE_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COS:    cos_q    <= cfg_data[TRIG_W-1:0];
				REG_SIN:    sin_q    <= cfg_data[TRIG_W-1:0];
				REG_QUAD:   quad_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Magnitudes of the trig values; the most negative code gives 32768.
	assign cos_ext = {cos_q[TRIG_W-1], cos_q};
	assign sin_ext = {sin_q[TRIG_W-1], sin_q};

	always_comb begin
		cfg.cos_v = cos_q;
		cfg.sin_v = sin_q;
		cfg.abs_c = cos_q[TRIG_W-1] ? (~cos_ext + (TRIG_W+1)'(1)) : cos_ext;
		cfg.abs_s = sin_q[TRIG_W-1] ? (~sin_ext + (TRIG_W+1)'(1)) : sin_ext;
		cfg.quad  = quad_q;
		cfg.w     = eff_size(width_q, MAX_WIDTH);
		cfg.h     = eff_size(height_q, MAX_HEIGHT);
	end

endmodule

FILE: design/image_rotate_nearest.sv
// A store, or a read outside the rotated size, strobes done after the size steps SZ0 to SZ3
// and the check CHK; an in-range read goes on through DELTA, M0 to M4, RD and OUT. A new item
// is taken only when idle, once the last is done; the single shared 27x17 multiplier works
// the sizes, offset and rotation in turn, then the pixel store read. The receiver cannot stall.
// Reset clears configuration to its defaults and the sequencer to idle; the pixel store is
// not cleared and holds nothing meaningful until written.
module image_rotate_nearest import irn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [PIX_W-1:0]     pixel_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 done,
	output logic [PIX_W-1:0]     pixel_out,
	output logic [COORD_W-1:0]   source_col,
	output logic [COORD_W-1:0]   source_row,
	output logic [OUTSZ_W-1:0]   out_width,
	output logic [OUTSZ_W-1:0]   out_height,
	output logic                 status
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SZ0   = 4'd1;
	localparam logic [3:0] ST_SZ1   = 4'd2;
	localparam logic [3:0] ST_SZ2   = 4'd3;
	localparam logic [3:0] ST_SZ3   = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_DELTA = 4'd6;
	localparam logic [3:0] ST_M0    = 4'd7;
	localparam logic [3:0] ST_M1    = 4'd8;
	localparam logic [3:0] ST_M2    = 4'd9;
	localparam logic [3:0] ST_M3    = 4'd10;
	localparam logic [3:0] ST_M4    = 4'd11;
	localparam logic [3:0] ST_RD    = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	localparam logic REQ_STORE = 1'b0;

	cfg_t cfg;

	logic [3:0]              state_q;
	logic                    req_q;
	logic [POS_W-1:0]        x_q;
	logic [POS_W-1:0]        y_q;
	logic [PIX_W-1:0]        pix_in_q;

	logic signed [OPA_W-1:0]  mul_a;
	logic signed [OPB_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum_q;
	logic signed [ACC_W-1:0]  sum_add;
	logic signed [ACC_W-1:0]  sum_sub;
	logic [DIM_W-1:0]         size_next;
	logic [DIM_W-1:0]         w1_q;
	logic [DIM_W-1:0]         h1_q;

	logic signed [OPA_W-1:0] op_w;
	logic signed [OPA_W-1:0] op_h;
	logic signed [OPA_W-1:0] op_wm1;
	logic signed [OPA_W-1:0] op_hm1;
	logic signed [OPB_W-1:0] op_c;
	logic signed [OPB_W-1:0] op_s;
	logic signed [OPB_W-1:0] op_ac;
	logic signed [OPB_W-1:0] op_as;

	logic signed [OPA_W-1:0] x_f;
	logic signed [OPA_W-1:0] y_f;
	logic signed [OPA_W-1:0] ofs_p;
	logic signed [DIM_W:0]   x_diff;
	logic signed [DIM_W:0]   y_diff;
	logic signed [OPA_W-1:0] x_diff_f;
	logic signed [OPA_W-1:0] y_diff_f;
	logic signed [OPA_W-1:0] dx_next;
	logic signed [OPA_W-1:0] dy_next;
	logic signed [OPA_W-1:0] dx_q;
	logic signed [OPA_W-1:0] dy_q;

	logic [COORD_W-1:0] sx_q;
	logic [COORD_W-1:0] sy_q;
	logic [COORD_W-1:0] sy_next;

	logic store_ok;
	logic read_out;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [PIX_W-1:0]  ram_rdata;

	logic               done_q;
	logic [PIX_W-1:0]   pix_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [OUTSZ_W-1:0] wid_q;
	logic [OUTSZ_W-1:0] hgt_q;
	logic               stat_q;

	// Round half away from zero and clamp to [0, lim-1]; a negative sum always clamps to 0.
	function automatic logic [COORD_W-1:0] round_clamp(input logic signed [ACC_W-1:0] v,
			input logic [SIZE_W-1:0] lim);
		logic [ACC_W-1:0]             t;
		logic [ACC_W-2*FRAC_BITS-1:0] q;
		logic [SIZE_W-1:0]            top;
		logic [COORD_W-1:0]           r;
		t   = ACC_W'(v) + (ACC_W'(1) << (2*FRAC_BITS - 1));
		q   = t[ACC_W-1:2*FRAC_BITS];
		top = lim - SIZE_W'(1);
		if (v[ACC_W-1]) begin
			r = '0;
		end else if (q > (ACC_W-2*FRAC_BITS)'(top)) begin
			r = top[COORD_W-1:0];
		end else begin
			r = q[COORD_W-1:0];
		end
		return r;
	endfunction

	// Rotated sizes saturate at the largest value the port can show.
	function automatic logic [OUTSZ_W-1:0] sat_size(input logic [DIM_W-1:0] v);
		return (|v[DIM_W-1:OUTSZ_W]) ? {OUTSZ_W{1'b1}} : v[OUTSZ_W-1:0];
	endfunction

	irn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	irn_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (pix_in_q),
		.rdata (ram_rdata)
	);

	assign busy = (state_q != ST_IDLE);

	// Multiplier operands.
	assign op_w   = OPA_W'(cfg.w);
	assign op_h   = OPA_W'(cfg.h);
	assign op_wm1 = OPA_W'(cfg.w - SIZE_W'(1));
	assign op_hm1 = OPA_W'(cfg.h - SIZE_W'(1));
	assign op_c   = OPB_W'($signed(cfg.cos_v));
	assign op_s   = OPB_W'($signed(cfg.sin_v));
	assign op_ac  = $signed(cfg.abs_c);
	assign op_as  = $signed(cfg.abs_s);

	// Operand selection for the shared multiplier, by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SZ0: begin
				mul_a = op_w;
				mul_b = op_ac;
			end
			ST_SZ1: begin
				mul_a = op_h;
				mul_b = op_as;
			end
			ST_SZ2: begin
				mul_a = op_h;
				mul_b = op_ac;
			end
			ST_SZ3: begin
				mul_a = op_w;
				mul_b = op_as;
			end
			ST_CHK: begin
				case (cfg.quad)
					QUAD_0: begin
						mul_a = op_wm1;
						mul_b = op_s;
					end
					QUAD_1: begin
						mul_a = op_wm1;
						mul_b = op_c;
					end
					QUAD_2: begin
						mul_a = op_hm1;
						mul_b = op_c;
					end
					default: begin
						mul_a = op_hm1;
						mul_b = op_s;
					end
				endcase
			end
			ST_M0: begin
				mul_a = dx_q;
				mul_b = op_c;
			end
			ST_M1: begin
				mul_a = dy_q;
				mul_b = op_s;
			end
			ST_M2: begin
				mul_a = dx_q;
				mul_b = op_s;
			end
			ST_M3: begin
				mul_a = dy_q;
				mul_b = op_c;
			end
			default: ;
		endcase
	end

	// Registered product.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign sum_add   = acc_q + ACC_W'(prod_q);
	assign sum_sub   = acc_q - ACC_W'(prod_q);
	assign size_next = sum_add[FRAC_BITS +: DIM_W];

	// Range checks for stores and reads.
	assign store_ok = (x_q < cfg.w) && (y_q < cfg.h);
	assign read_out = (DIM_W'(x_q) >= w1_q) || (DIM_W'(y_q) >= size_next);

	// Destination minus the quadrant's offset, in the same fraction format as the trig values.
	assign x_f      = OPA_W'(x_q) <<< FRAC_BITS;
	assign y_f      = OPA_W'(y_q) <<< FRAC_BITS;
	assign ofs_p    = prod_q[OPA_W-1:0];
	assign x_diff   = $signed({2'b00, x_q}) - $signed({1'b0, w1_q}) + (DIM_W+1)'(1);
	assign y_diff   = $signed({2'b00, y_q}) - $signed({1'b0, h1_q}) + (DIM_W+1)'(1);
	assign x_diff_f = OPA_W'(x_diff) <<< FRAC_BITS;
	assign y_diff_f = OPA_W'(y_diff) <<< FRAC_BITS;

	always_comb begin
		case (cfg.quad)
			QUAD_0: begin
				dx_next = x_f;
				dy_next = y_f - ofs_p;
			end
			QUAD_1: begin
				dx_next = x_f + ofs_p;
				dy_next = y_diff_f;
			end
			QUAD_2: begin
				dx_next = x_diff_f;
				dy_next = y_f + ofs_p;
			end
			default: begin
				dx_next = x_f + ofs_p;
				dy_next = y_f;
			end
		endcase
	end

	assign sy_next = round_clamp(sum_q, cfg.h);

	// Pixel store access: write on an in-window store, read at the sampled source pixel.
	assign ram_we = (state_q == ST_CHK) && (req_q == REQ_STORE) && store_ok;

	always_comb begin
		if (state_q == ST_RD) begin
			ram_addr = ADDR_W'(sy_next) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_q);
		end else begin
			ram_addr = ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q    <= req_type;
			x_q      <= pos_x;
			y_q      <= pos_y;
			pix_in_q <= pixel_in;
		end
		case (state_q)
			ST_SZ1:   acc_q <= ACC_W'(prod_q);
			ST_SZ2:   w1_q  <= size_next;
			ST_SZ3:   acc_q <= ACC_W'(prod_q);
			ST_CHK:   h1_q  <= size_next;
			ST_DELTA: begin
				dx_q <= dx_next;
				dy_q <= dy_next;
			end
			ST_M1:    acc_q <= ACC_W'(prod_q);
			ST_M2:    sum_q <= sum_sub;
			ST_M3: begin
				acc_q <= ACC_W'(prod_q);
				sx_q  <= round_clamp(sum_q, cfg.w);
			end
			ST_M4:    sum_q <= sum_add;
			ST_RD:    sy_q  <= sy_next;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  state_q <= (start) ? ST_SZ0 : ST_IDLE;
				ST_SZ0:   state_q <= ST_SZ1;
				ST_SZ1:   state_q <= ST_SZ2;
				ST_SZ2:   state_q <= ST_SZ3;
				ST_SZ3:   state_q <= ST_CHK;
				ST_CHK:   state_q <= (req_q == REQ_STORE || read_out) ? ST_IDLE : ST_DELTA;
				ST_DELTA: state_q <= ST_M0;
				ST_M0:    state_q <= ST_M1;
				ST_M1:    state_q <= ST_M2;
				ST_M2:    state_q <= ST_M3;
				ST_M3:    state_q <= ST_M4;
				ST_M4:    state_q <= ST_RD;
				ST_RD:    state_q <= ST_OUT;
				ST_OUT:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_OUT) ||
				((state_q == ST_CHK) && (req_q == REQ_STORE || read_out));
		end
	end

	// Result beat: stores and out-of-range reads finish after the checks, others after the read.
	always_ff @(posedge clk) begin
		if (state_q == ST_CHK) begin
			pix_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			wid_q  <= sat_size(w1_q);
			hgt_q  <= sat_size(size_next);
			stat_q <= (req_q == REQ_STORE) ? !store_ok : 1'b1;
		end else if (state_q == ST_OUT) begin
			pix_q  <= ram_rdata;
			col_q  <= sx_q;
			row_q  <= sy_q;
			wid_q  <= sat_size(w1_q);
			hgt_q  <= sat_size(h1_q);
			stat_q <= 1'b0;
		end
	end

	assign done       = done_q;
	assign pixel_out  = pix_q;
	assign source_col = col_q;
	assign source_row = row_q;
	assign out_width  = wid_q;
	assign out_height = hgt_q;
	assign status     = stat_q;

endmodule
